@@ src/image_header_size_parser_top_macros.svh @@
// assertion macros shared by the checker
`ifndef IMAGE_HEADER_SIZE_PARSER_TOP_MACROS_SVH
`define IMAGE_HEADER_SIZE_PARSER_TOP_MACROS_SVH

// consequent must hold in the same cycle
`define IHSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define IHSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ihsp_pkg.sv @@
package ihsp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PNG,
        PH_SOI,
        PH_SCAN,
        PH_MARK,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SOFL_HI,
        PH_SOFL_LO,
        PH_SKIP,
        PH_PREC,
        PH_H1,
        PH_H0,
        PH_W1,
        PH_W0
    } phase_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_FAIL,
        RES_PNG,
        RES_JPEG
    } res_t;

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  pos;
        logic [15:0] skip;
        logic [7:0]  len_hi;
        logic [31:0] width;
        logic [31:0] height;
    } parse_state_t;

    localparam parse_state_t IDLE_STATE = '{
        phase:  PH_IDLE,
        pos:    5'd0,
        skip:   16'd0,
        len_hi: 8'd0,
        width:  32'd0,
        height: 32'd0
    };

    // image_format codes
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_PNG  = 2'd1;
    localparam logic [1:0] FMT_JPEG = 2'd2;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] JPEG_SOI  = 8'hD8;
    localparam logic [7:0] JPEG_EOI  = 8'hD9;
    localparam logic [7:0] JPEG_SOS  = 8'hDA;
    localparam logic [7:0] SOF_FIRST = 8'hC0;
    localparam logic [7:0] SOF_LAST  = 8'hCF;
    localparam logic [7:0] JPEG_DHT  = 8'hC4;
    localparam logic [7:0] JPEG_JPG  = 8'hC8;
    localparam logic [7:0] JPEG_DAC  = 8'hCC;

    localparam logic [4:0]  PNG_LAST_POS = 5'd23;
    localparam logic [15:0] SEG_LEN_MIN  = 16'd2;
    localparam logic [15:0] SOF_LEN_MIN  = 16'd7;

    function automatic logic [7:0] png_sig(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h89;
            2'd1: b = 8'h50;
            2'd2: b = 8'h4E;
            2'd3: b = 8'h47;
            default: b = 8'h89;
        endcase
        return b;
    endfunction

    function automatic logic dims_ok(input logic [31:0] w, input logic [31:0] h);
        return (w != 32'd0) && !w[31] && (h != 32'd0) && !h[31];
    endfunction

endpackage

@@ src/image_header_size_parser_top.sv @@
// Image header size parser: takes an image file one byte per transaction
// (first_byte marks byte 0, last_byte the final byte) and gives one result
// transaction per file with the pixel size. PNG files give the big-endian
// words at bytes 16..23; JPEG files are walked marker by marker up to the
// first SOF segment. A failure (bad signature, EOI/SOS before a SOF, short
// segment length, zero or negative size, or a file that ends first) gives
// found 0, format 0 and zero sizes. Bytes after the result are dropped
// until the next first_byte. The block takes one byte every cycle while
// byte_stall is low: each byte passes from an input register through a
// combinational parse step into the parser state and the result register.
// byte_stall rises only while a result sits in the result register and
// size_stall holds it there.
module image_header_size_parser_top import ihsp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    // size result channel
    output logic        size_valid,
    input  logic        size_stall,
    output logic        found,
    output logic [1:0]  image_format,
    output logic [30:0] image_width,
    output logic [30:0] image_height
);

    // input register
    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_first_reg;
    logic         in_last_reg;

    // parser state
    parse_state_t state_reg;
    parse_state_t state_next;
    res_t         step_res;

    // result register
    logic         out_valid_reg;
    logic         found_reg;
    logic [1:0]   format_reg;
    logic [30:0]  width_reg;
    logic [30:0]  height_reg;

    logic         advance;
    logic         success;

    // the parse step may run whenever the result register can take a value
    assign advance    = !out_valid_reg || !size_stall;
    assign byte_stall = in_valid_reg && !advance;
    assign success    = (step_res == RES_PNG) || (step_res == RES_JPEG);

    ihsp_parse_step u_step (
        .cur_state  (state_reg),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .nxt_state  (state_next),
        .result     (step_res)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!byte_stall)
            in_valid_reg <= byte_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_data_reg  <= data_byte;
            in_first_reg <= first_byte;
            in_last_reg  <= last_byte;
        end
    end

    // parser state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE_STATE;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_valid_reg)
                state_reg <= state_next;
            out_valid_reg <= in_valid_reg && (step_res != RES_NONE);
        end
    end

    // result payload, zero sizes on failure
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && (step_res != RES_NONE))
        begin
            found_reg  <= success;
            format_reg <= (step_res == RES_PNG)  ? FMT_PNG :
                          (step_res == RES_JPEG) ? FMT_JPEG : FMT_NONE;
            width_reg  <= success ? state_next.width[30:0]  : 31'd0;
            height_reg <= success ? state_next.height[30:0] : 31'd0;
        end
    end

    assign size_valid   = out_valid_reg;
    assign found        = found_reg;
    assign image_format = format_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

@@ src/ihsp_parse_step.sv @@
module ihsp_parse_step import ihsp_pkg::*; (
    input  parse_state_t cur_state,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    input  logic         last_byte,
    output parse_state_t nxt_state,
    output res_t         result
);

    parse_state_t eff;
    logic         active;
    logic         is_sof;
    logic         in_width;
    logic         in_height;
    logic [15:0]  seg_len;
    logic [31:0]  png_width;
    logic [31:0]  png_height;
    logic [31:0]  jpeg_width;
    res_t         adv_res;

    // a first byte restarts from a clean state
    always_comb
    begin
        eff = cur_state;
        if (first_byte)
        begin
            eff       = IDLE_STATE;
            eff.phase = PH_PNG;
        end
    end

    assign active    = first_byte || (cur_state.phase != PH_IDLE);
    assign is_sof    = (data_byte >= SOF_FIRST) && (data_byte <= SOF_LAST) &&
                       (data_byte != JPEG_DHT) && (data_byte != JPEG_JPG) &&
                       (data_byte != JPEG_DAC);
    assign seg_len   = {eff.len_hi, data_byte};
    assign in_width  = (eff.pos[4:2] == 3'b100);
    assign in_height = (eff.pos[4:2] == 3'b101);
    assign png_width  = in_width  ? {eff.width[23:0], data_byte}  : eff.width;
    assign png_height = in_height ? {eff.height[23:0], data_byte} : eff.height;
    assign jpeg_width = {16'd0, eff.width[7:0], data_byte};

    // result of this byte
    always_comb
    begin
        adv_res = RES_NONE;
        if (first_byte && (data_byte == BYTE_FF))
        begin
            adv_res = RES_NONE;
        end
        else
        begin
            unique case (eff.phase)
                PH_PNG:
                begin
                    if ((eff.pos[4:2] == 3'b000) && (data_byte != png_sig(eff.pos[1:0])))
                        adv_res = RES_FAIL;
                    else if (eff.pos >= PNG_LAST_POS)
                        adv_res = dims_ok(png_width, png_height) ? RES_PNG : RES_FAIL;
                end
                PH_SOI:
                    adv_res = (data_byte != JPEG_SOI) ? RES_FAIL : RES_NONE;
                PH_MARK:
                    adv_res = ((data_byte == JPEG_EOI) || (data_byte == JPEG_SOS)) ?
                              RES_FAIL : RES_NONE;
                PH_LEN_LO, PH_SOFL_LO:
                    adv_res = (seg_len < SEG_LEN_MIN) ? RES_FAIL : RES_NONE;
                PH_W0:
                    adv_res = dims_ok(jpeg_width, eff.height) ? RES_JPEG : RES_FAIL;
                PH_IDLE, PH_SCAN, PH_LEN_HI, PH_SOFL_HI, PH_SKIP, PH_PREC, PH_H1,
                PH_H0, PH_W1:
                    adv_res = RES_NONE;
                default:
                    adv_res = RES_FAIL;
            endcase
        end

        result = RES_NONE;
        if (active)
        begin
            if ((adv_res == RES_NONE) && last_byte)
                result = RES_FAIL;
            else
                result = adv_res;
        end
    end

    // next parser state
    always_comb
    begin
        nxt_state = eff;
        if (first_byte && (data_byte == BYTE_FF))
        begin
            nxt_state.phase = PH_SOI;
        end
        else
        begin
            unique case (eff.phase)
                PH_PNG:
                begin
                    nxt_state.width  = png_width;
                    nxt_state.height = png_height;
                    nxt_state.pos    = eff.pos + 5'd1;
                end
                PH_SOI:
                    nxt_state.phase = PH_SCAN;
                PH_SCAN:
                    if (data_byte == BYTE_FF)
                        nxt_state.phase = PH_MARK;
                PH_MARK:
                    if (data_byte != BYTE_FF)
                        nxt_state.phase = is_sof ? PH_SOFL_HI : PH_LEN_HI;
                PH_LEN_HI:
                begin
                    nxt_state.len_hi = data_byte;
                    nxt_state.phase  = PH_LEN_LO;
                end
                PH_SOFL_HI:
                begin
                    nxt_state.len_hi = data_byte;
                    nxt_state.phase  = PH_SOFL_LO;
                end
                PH_LEN_LO, PH_SOFL_LO:
                begin
                    if ((eff.phase == PH_SOFL_LO) && (seg_len >= SOF_LEN_MIN))
                        nxt_state.phase = PH_PREC;
                    else if (seg_len == SEG_LEN_MIN)
                        nxt_state.phase = PH_SCAN;
                    else
                    begin
                        nxt_state.skip  = seg_len - SEG_LEN_MIN;
                        nxt_state.phase = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (eff.skip <= 16'd1)
                    begin
                        nxt_state.skip  = 16'd0;
                        nxt_state.phase = PH_SCAN;
                    end
                    else
                        nxt_state.skip = eff.skip - 16'd1;
                end
                PH_PREC:
                    nxt_state.phase = PH_H1;
                PH_H1:
                begin
                    nxt_state.height = {24'd0, data_byte};
                    nxt_state.phase  = PH_H0;
                end
                PH_H0:
                begin
                    nxt_state.height = {16'd0, eff.height[7:0], data_byte};
                    nxt_state.phase  = PH_W1;
                end
                PH_W1:
                begin
                    nxt_state.width = {24'd0, data_byte};
                    nxt_state.phase = PH_W0;
                end
                PH_W0:
                    nxt_state.width = jpeg_width;
                PH_IDLE:
                    nxt_state = eff;
                default:
                    nxt_state.phase = PH_IDLE;
            endcase
        end

        if (result != RES_NONE)
            nxt_state.phase = PH_IDLE;
    end

endmodule

@@ src/ihsp_checker.sv @@
`include "image_header_size_parser_top_macros.svh"

module ihsp_checker import ihsp_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_stall,
    input logic        size_valid,
    input logic        size_stall,
    input logic        found,
    input logic [1:0]  image_format,
    input logic [30:0] image_width,
    input logic [30:0] image_height
);

    // a stalled result stays offered
    `IHSP_ASSERT_NEXT(a_size_hold, size_valid && size_stall, size_valid, "stalled result dropped")

    // a stalled result does not change
    `IHSP_ASSERT_NEXT(a_size_stable, size_valid && size_stall, $stable(found) && $stable(image_format) && $stable(image_width) && $stable(image_height), "stalled result changed")

    // found goes with a known format and nonzero sizes
    `IHSP_ASSERT_SAME(a_found_format, size_valid && found, (image_format == FMT_PNG || image_format == FMT_JPEG) && image_width != 31'd0 && image_height != 31'd0, "found without format or size")

    // failure reports no format and zero sizes
    `IHSP_ASSERT_SAME(a_fail_zero, size_valid && !found, image_format == FMT_NONE && image_width == 31'd0 && image_height == 31'd0, "failure with nonzero fields")

    // the byte side only backs up behind a held result
    `IHSP_ASSERT_SAME(a_byte_stall_cause, byte_stall, size_valid && size_stall, "byte stall without a held result")

endmodule

bind image_header_size_parser_top ihsp_checker u_ihsp_checker (.*);

@@ tb/tb_image_header_size_parser_top.sv @@
module tb_image_header_size_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ihsp_pkg::*;

    // run shape
    localparam int NUM_ITEMS    = 1450;      // byte transactions in the whole run
    localparam int IDLE_PCT     = 9;         // chance of an idle cycle on either side
    localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;        // wait after the drain for stray results
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TIMEOUT_NS   = 4_000_000;

    // png signature bytes, byte 0 in the top lane
    localparam logic [31:0] PNG_MAGIC        = 32'h89504E47;
    localparam logic [7:0]  SAMPLE_PRECISION = 8'd8;
    localparam logic [7:0]  APP0_MARKER      = 8'hE0;
    localparam logic [7:0]  APP1_MARKER      = 8'hE1;
    localparam logic [7:0]  APP2_MARKER      = 8'hE2;

    typedef logic [7:0] byte_q_t [$];

    // one size transaction as the block reports it
    typedef struct packed {
        logic        found;
        logic [1:0]  fmt;
        logic [30:0] width;
        logic [30:0] height;
    } size_rec_t;

    // dut ports, every input known from time zero
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte  = 8'h00;
    logic        first_byte = 1'b0;
    logic        last_byte  = 1'b0;
    logic        size_valid;
    logic        size_stall = 1'b0;
    logic        found;
    logic [1:0]  image_format;
    logic [30:0] image_width;
    logic [30:0] image_height;

    // shadow copy of the parser state
    phase_t      prs_phase  = PH_IDLE;
    logic [4:0]  prs_pos    = '0;
    logic [15:0] prs_skip   = '0;
    logic [7:0]  prs_len_hi = '0;
    logic [31:0] prs_width  = '0;
    logic [31:0] prs_height = '0;
    bit          prs_done   = 1'b1;

    // sizes waiting for their output transaction, oldest first
    size_rec_t   expected_sizes [$];
    // file being assembled by the stimulus builders
    byte_q_t     file_bytes;

    int          fail_count   = 0;
    int          bytes_sent   = 0;
    bit          idle_on      = 1'b1;
    // hold-off request from the tests, counted out by the receiver
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;

    image_header_size_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .size_valid   (size_valid),
        .size_stall   (size_stall),
        .found        (found),
        .image_format (image_format),
        .image_width  (image_width),
        .image_height (image_height)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // size predictor
    // ------------------------------------------------------------------

    // start of frame markers: c0..cf without dht, jpg and dac
    function automatic bit is_sof_marker(input logic [7:0] m);
        return m >= SOF_FIRST && m <= SOF_LAST && m != JPEG_DHT && m != JPEG_JPG
            && m != JPEG_DAC;
    endfunction

    // both sizes must be positive as signed 32-bit words
    function automatic res_t size_verdict(input res_t fmt);
        if (prs_width != 32'd0 && !prs_width[31] && prs_height != 32'd0 && !prs_height[31])
            return fmt;
        return RES_FAIL;
    endfunction

    // second length byte of a segment decides where the walk goes next
    function automatic res_t take_seg_length(input logic [7:0] b, input bit is_sof);
        logic [15:0] len;
        len = {prs_len_hi, b};
        if (len < SEG_LEN_MIN)
            return RES_FAIL;
        if (is_sof && len >= SOF_LEN_MIN)
            prs_phase = PH_PREC;
        else if (len == SEG_LEN_MIN)
            prs_phase = PH_SCAN;
        else
        begin
            prs_skip  = len - SEG_LEN_MIN;
            prs_phase = PH_SKIP;
        end
        return RES_NONE;
    endfunction

    // one byte of an open file
    function automatic res_t parse_byte(input logic [7:0] b);
        res_t       r;
        logic [4:0] p;
        r = RES_NONE;
        p = prs_pos;
        case (prs_phase)
            PH_PNG:
            begin
                if (p < 5'd4 && b != PNG_MAGIC[8 * (3 - p[1:0]) +: 8])
                    r = RES_FAIL;
                else
                begin
                    if (p >= 5'd16 && p < 5'd20)
                        prs_width = {prs_width[23:0], b};
                    else if (p >= 5'd20 && p < 5'd24)
                        prs_height = {prs_height[23:0], b};
                    if (p >= PNG_LAST_POS)
                        r = size_verdict(RES_PNG);
                    else
                        prs_pos = p + 5'd1;
                end
            end
            PH_SOI:
            begin
                if (b != JPEG_SOI)
                    r = RES_FAIL;
                else
                    prs_phase = PH_SCAN;
            end
            PH_SCAN:
            begin
                if (b == BYTE_FF)
                    prs_phase = PH_MARK;
            end
            PH_MARK:
            begin
                if (b == BYTE_FF)
                    r = RES_NONE;
                else if (b == JPEG_EOI || b == JPEG_SOS)
                    r = RES_FAIL;
                else if (is_sof_marker(b))
                    prs_phase = PH_SOFL_HI;
                else
                    prs_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                prs_len_hi = b;
                prs_phase  = PH_LEN_LO;
            end
            PH_LEN_LO:
                r = take_seg_length(b, 1'b0);
            PH_SOFL_HI:
            begin
                prs_len_hi = b;
                prs_phase  = PH_SOFL_LO;
            end
            PH_SOFL_LO:
                r = take_seg_length(b, 1'b1);
            PH_SKIP:
            begin
                if (prs_skip <= 16'd1)
                begin
                    prs_skip  = 16'd0;
                    prs_phase = PH_SCAN;
                end
                else
                    prs_skip = prs_skip - 16'd1;
            end
            PH_PREC:
                prs_phase = PH_H1;
            PH_H1:
            begin
                prs_height = {24'd0, b};
                prs_phase  = PH_H0;
            end
            PH_H0:
            begin
                prs_height = {16'd0, prs_height[7:0], b};
                prs_phase  = PH_W1;
            end
            PH_W1:
            begin
                prs_width = {24'd0, b};
                prs_phase = PH_W0;
            end
            PH_W0:
            begin
                prs_width = {16'd0, prs_width[7:0], b};
                r = size_verdict(RES_JPEG);
            end
            default:
                r = RES_FAIL;
        endcase
        return r;
    endfunction

    // runs on every accepted byte transaction, queues the size it causes
    task automatic predict_size(input logic [7:0] b, input bit is_first, input bit is_last);
        res_t      r;
        size_rec_t rec;
        if (is_first)
        begin
            // a new file drops whatever was open
            prs_pos    = '0;
            prs_skip   = '0;
            prs_len_hi = '0;
            prs_width  = '0;
            prs_height = '0;
            prs_done   = 1'b0;
            if (b == BYTE_FF)
            begin
                prs_phase = PH_SOI;
                r = RES_NONE;
            end
            else
            begin
                prs_phase = PH_PNG;
                r = parse_byte(b);
            end
        end
        else if (prs_done)
            return;
        else
            r = parse_byte(b);

        // file ends without a verdict
        if (r == RES_NONE && is_last)
            r = RES_FAIL;
        if (r == RES_NONE)
            return;

        rec = '0;
        if (r != RES_FAIL)
        begin
            rec.found  = 1'b1;
            rec.fmt    = (r == RES_PNG) ? FMT_PNG : FMT_JPEG;
            rec.width  = prs_width[30:0];
            rec.height = prs_height[30:0];
        end
        expected_sizes.push_back(rec);
        prs_done  = 1'b1;
        prs_phase = PH_IDLE;
    endtask

    // ------------------------------------------------------------------
    // byte sender
    // ------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input bit is_first, input bit is_last);
        bytes_sent++;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        first_byte <= is_first;
        last_byte  <= is_last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        predict_size(b, is_first, is_last);
        @(negedge clk);
    endtask

    // first count bytes of the assembled file, last_byte on the final one if asked
    task automatic send_file(input int count, input bit with_last);
        for (int i = 0; i < count; i++)
            send_byte(file_bytes[i], i == 0, with_last && i == count - 1);
    endtask

    task automatic send_whole_file();
        send_file(file_bytes.size(), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // file builders
    // ------------------------------------------------------------------

    task automatic make_png(input logic [31:0] w, input logic [31:0] h);
        file_bytes = {};
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(PNG_MAGIC[8 * (3 - i) +: 8]);
        // rest of the signature and the chunk header: content does not matter
        for (int i = 4; i < 16; i++)
            file_bytes.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(w[8 * i +: 8]);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(h[8 * i +: 8]);
    endtask

    task automatic make_jpeg_start();
        file_bytes = {};
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(JPEG_SOI);
    endtask

    // marker, length and len-2 bytes of payload
    task automatic add_segment(input logic [7:0] m, input logic [15:0] len);
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(m);
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
        for (int i = 2; i < len; i++)
            file_bytes.push_back(8'($urandom));
    endtask

    task automatic add_sof(input logic [7:0] m, input logic [15:0] len,
                           input logic [15:0] h, input logic [15:0] w);
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(m);
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
        file_bytes.push_back(SAMPLE_PRECISION);
        file_bytes.push_back(h[15:8]);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
        for (int i = 7; i < len; i++)
            file_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [31:0] rand_png_dim();
        int k;
        k = $urandom_range(19);
        if (k < 13)
            return $urandom_range(1, 65535);
        if (k < 16)
            return $urandom;
        if (k == 16)
            return 32'd0;
        if (k == 17)
            return 32'h7FFF_FFFF;
        return 32'h8000_0000;
    endfunction

    function automatic logic [15:0] rand_jpeg_dim();
        int k;
        k = $urandom_range(19);
        if (k < 17)
            return 16'($urandom_range(1, 65535));
        if (k < 19)
            return 16'd0;
        return 16'hFFFF;
    endfunction

    function automatic logic [7:0] rand_sof_marker();
        logic [7:0] m;
        do
            m = 8'($urandom_range(SOF_FIRST, SOF_LAST));
        while (!is_sof_marker(m));
        return m;
    endfunction

    // any marker that opens a plain segment
    function automatic logic [7:0] rand_plain_marker();
        logic [7:0] m;
        int         k;
        k = $urandom_range(3);
        if (k == 0)
            return JPEG_DHT;
        if (k == 1)
            return ($urandom_range(1) != 0) ? JPEG_JPG : JPEG_DAC;
        do
            m = 8'($urandom_range(254));
        while (m == JPEG_EOI || m == JPEG_SOS || is_sof_marker(m));
        return m;
    endfunction

    // mostly well-formed png or jpeg headers with random content, some broken, some noise
    task automatic make_random_file();
        int kind;
        int nseg;
        int n;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            make_png(rand_png_dim(), rand_png_dim());
            // damaged signature now and then
            if ($urandom_range(19) == 0)
                file_bytes[$urandom_range(3)] = 8'($urandom);
        end
        else if (kind < 85)
        begin
            make_jpeg_start();
            if ($urandom_range(29) == 0)
                file_bytes[1] = 8'($urandom);
            nseg = $urandom_range(3);
            for (int s = 0; s < nseg; s++)
            begin
                // fill bytes and stray bytes between segments
                if ($urandom_range(3) == 0)
                    file_bytes.push_back(BYTE_FF);
                if ($urandom_range(4) == 0)
                    file_bytes.push_back(8'($urandom));
                case ($urandom_range(11))
                    0:
                        // sof too short for a size, walked over
                        add_segment(rand_sof_marker(), 16'($urandom_range(2, 6)));
                    1:
                    begin
                        file_bytes.push_back(BYTE_FF);
                        file_bytes.push_back(($urandom_range(1) != 0) ? JPEG_EOI : JPEG_SOS);
                    end
                    2:
                    begin
                        file_bytes.push_back(BYTE_FF);
                        file_bytes.push_back(rand_plain_marker());
                        file_bytes.push_back(8'h00);
                        file_bytes.push_back(8'($urandom_range(1)));
                    end
                    default:
                        add_segment(rand_plain_marker(), 16'($urandom_range(2, 12)));
                endcase
            end
            add_sof(rand_sof_marker(), 16'($urandom_range(7, 12)), rand_jpeg_dim(),
                    rand_jpeg_dim());
        end
        else
        begin
            // noise, sometimes with a plausible first byte
            file_bytes = {};
            n = $urandom_range(1, 24);
            case ($urandom_range(2))
                0: file_bytes.push_back(PNG_MAGIC[31:24]);
                1: file_bytes.push_back(BYTE_FF);
                default: file_bytes.push_back(8'($urandom));
            endcase
            for (int i = 1; i < n; i++)
                file_bytes.push_back(8'($urandom));
        end
        // trailing bytes after the header
        repeat ($urandom_range(3))
            file_bytes.push_back(8'($urandom));
    endtask

    // whole file, truncated file, or one left open for the next file to drop
    task automatic send_random_file();
        int k;
        make_random_file();
        k = $urandom_range(19);
        if (k < 3)
            send_file($urandom_range(1, file_bytes.size()), 1'b1);
        else if (k == 3)
            send_file(file_bytes.size(), 1'b0);
        else
            send_whole_file();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_png_cases();
        // smallest and largest positive sizes
        make_png(32'd1, 32'd1);
        send_whole_file();
        make_png(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_whole_file();
        // zero width, negative height, all ones
        make_png(32'd0, 32'd5);
        send_whole_file();
        make_png(32'd10, 32'h8000_0000);
        send_whole_file();
        make_png(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_whole_file();
        // bad signature byte, rest of the file ignored
        make_png(32'd5, 32'd5);
        file_bytes[2] = 8'h00;
        send_whole_file();
        // unknown start byte
        make_png(32'd5, 32'd5);
        file_bytes[0] = 8'h42;
        send_whole_file();
        // truncated inside the width word
        make_png(32'd640, 32'd480);
        send_file(18, 1'b1);
        // bytes after the result
        make_png(32'd3, 32'd4);
        repeat (4)
            file_bytes.push_back(8'($urandom));
        send_whole_file();
        // restart mid-file: no last byte, the next file drops it
        make_png(32'd9, 32'd9);
        send_file(12, 1'b0);
        // one byte files, first and last together
        file_bytes = {PNG_MAGIC[31:24]};
        send_whole_file();
        file_bytes = {BYTE_FF};
        send_whole_file();
    endtask

    task automatic test_jpeg_cases();
        // bare sof, smallest sizes
        make_jpeg_start();
        add_sof(SOF_FIRST, 16'd17, 16'd1, 16'd1);
        send_whole_file();
        // fill bytes, app0, empty dht, stray byte, last sof code, largest sizes
        make_jpeg_start();
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(BYTE_FF);
        add_segment(APP0_MARKER, 16'd16);
        add_segment(JPEG_DHT, 16'd2);
        file_bytes.push_back(8'h12);
        add_sof(SOF_LAST, 16'd11, 16'hFFFF, 16'hFFFF);
        send_whole_file();
        // end of image before any sof
        make_jpeg_start();
        add_segment(APP1_MARKER, 16'd4);
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(JPEG_EOI);
        file_bytes.push_back(8'h00);
        send_whole_file();
        // start of scan
        make_jpeg_start();
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(JPEG_SOS);
        send_whole_file();
        // length below two
        make_jpeg_start();
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(APP0_MARKER);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h01);
        send_whole_file();
        // short sof walked over, jpg and dac are not sof, then a real one
        make_jpeg_start();
        add_segment(8'hC2, 16'd6);
        add_segment(JPEG_JPG, 16'd3);
        add_segment(JPEG_DAC, 16'd2);
        add_sof(8'hC1, 16'd8, 16'd200, 16'd300);
        send_whole_file();
        // missing d8
        file_bytes = {BYTE_FF, 8'h00, 8'h55};
        send_whole_file();
        // zero height
        make_jpeg_start();
        add_sof(8'hC3, 16'd8, 16'd0, 16'd100);
        send_whole_file();
        // length with a nonzero high byte
        make_jpeg_start();
        add_segment(APP1_MARKER, 16'h0102);
        add_sof(8'hC9, 16'd7, 16'd48, 16'd64);
        send_whole_file();
        // longest length, file ends inside the skip
        make_jpeg_start();
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(APP2_MARKER);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        repeat (20)
            file_bytes.push_back(8'($urandom));
        send_whole_file();
    endtask

    // back to back bytes, receiver always ready
    task automatic test_no_idle_stretch();
        idle_on = 1'b0;
        repeat (15)
            send_random_file();
        idle_on = 1'b1;
    endtask

    // receiver holds off while short jpeg files keep coming, the block backs up
    task automatic test_output_holdoff();
        hold_req++;
        repeat (12)
        begin
            make_jpeg_start();
            add_sof(rand_sof_marker(), 16'd7, rand_jpeg_dim(), rand_jpeg_dim());
            send_whole_file();
        end
    endtask

    // random files until the run has sent its share of byte transactions
    task automatic test_random_files();
        while (bytes_sent < NUM_ITEMS)
            send_random_file();
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    // stall driven at the falling edge: long hold when asked, else random
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen  <= hold_req;
            hold_left  <= HOLD_CYCLES;
            size_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left  <= hold_left - 1;
            size_stall <= 1'b1;
        end
        else
            size_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // every accepted size transaction against the oldest prediction
    always @(posedge clk)
    begin : check_sizes
        size_rec_t want;
        if (rst_n && size_valid && !size_stall)
        begin
            if (expected_sizes.size() == 0)
            begin
                $error("size transaction with none expected: found %0d format %0d %0dx%0d",
                       found, image_format, image_width, image_height);
                fail_count++;
            end
            else
            begin
                want = expected_sizes.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("image_format", 32'(want.fmt), 32'(image_format));
                check_field("image_width", 32'(want.width), 32'(image_width));
                check_field("image_height", 32'(want.height), 32'(image_height));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        int guard;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_png_cases();
        test_jpeg_cases();
        test_no_idle_stretch();
        test_output_holdoff();
        test_random_files();
        byte_valid <= 1'b0;

        // drain what is still in flight, then wait DRAIN_CYCLES for strays
        guard = 0;
        while (expected_sizes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (expected_sizes.size() != 0)
        begin
            $error("%0d size transactions never arrived", expected_sizes.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("tb_image_header_size_parser_top passed");
        else
            $display("tb_image_header_size_parser_top failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_image_header_size_parser_top failed");
        $finish;
    end

endmodule

@@ image_header_size_parser_top.f @@
+incdir+src
src/ihsp_pkg.sv
src/ihsp_parse_step.sv
src/image_header_size_parser_top.sv
src/ihsp_checker.sv
tb/tb_image_header_size_parser_top.sv
